// File: design/bgvs_pkg.sv
// Shared types, constants and helpers of the grown vector stack.
`timescale 1ns / 1ps
`default_nettype none

package bgvs_pkg;

   localparam int DEPTH  = 1024;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = 11;
   localparam int CFG_W  = 11;
   localparam int DATA_W = 32;

   typedef logic [2:0] func_type;
   typedef logic [2:0] status_type;
   typedef logic       csr_index_type;

   localparam func_type FN_PUSH  = 3'd0;
   localparam func_type FN_POP   = 3'd1;
   localparam func_type FN_GET   = 3'd2;
   localparam func_type FN_SET   = 3'd3;
   localparam func_type FN_COUNT = 3'd4;

   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_OVERFLOW  = 3'd1;
   localparam status_type ST_ALLOC     = 3'd2;
   localparam status_type ST_UNDERFLOW = 3'd3;
   localparam status_type ST_INDEX     = 3'd4;
   localparam status_type ST_NOINIT    = 3'd5;

   localparam csr_index_type CSR_INIT_CAP   = 1'b0;
   localparam csr_index_type CSR_BLOCK_SIZE = 1'b1;

   localparam logic [CFG_W-1:0] INIT_CAP_RESET   = CFG_W'(16);
   localparam logic [CFG_W-1:0] BLOCK_SIZE_RESET = CFG_W'(16);

   // Request from the controller to the item memory.
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [DATA_W-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   // The starting capacity saturates at the size of the store.
   function automatic logic [CNT_W-1:0] eff_initial(input logic [CFG_W-1:0] init_cap);
      if (init_cap > CFG_W'(DEPTH)) begin
         return CNT_W'(DEPTH);
      end
      return CNT_W'(init_cap);
   endfunction

endpackage

`default_nettype wire

// File: design/bgvs_req_if.sv
// Request channel of the grown vector stack.
`timescale 1ns / 1ps
`default_nettype none

interface bgvs_req_if import bgvs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   func_type                 func;
   logic [CNT_W-1:0]         slot_index;
   logic signed [DATA_W-1:0] value_in;

   modport source (output valid, output func, output slot_index, output value_in,
                   input ready);
   modport sink (input valid, input func, input slot_index, input value_in,
                 output ready);
endinterface

`default_nettype wire

// File: design/bgvs_rsp_if.sv
// Response channel of the grown vector stack.
`timescale 1ns / 1ps
`default_nettype none

interface bgvs_rsp_if import bgvs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   status_type               status;
   logic signed [DATA_W-1:0] value_out;
   logic [CNT_W-1:0]         item_count;

   modport source (output valid, output status, output value_out, output item_count,
                   input ready);
   modport sink (input valid, input status, input value_out, input item_count,
                 output ready);
endinterface

`default_nettype wire

// File: design/bgvs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module bgvs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: design/bgvs_ctrl.sv
// Count, capacity and configuration state, operation decode and the response register.
`timescale 1ns / 1ps
`default_nettype none

module bgvs_ctrl import bgvs_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               clear_busy,
   bgvs_req_if.sink                req_if,
   bgvs_rsp_if.source              rsp_if,
   input  wire logic               csr_we,
   input  wire csr_index_type      csr_index,
   input  wire logic [CFG_W-1:0]   csr_wdata,
   output mem_req_type             mem_req,
   input  wire logic [DATA_W-1:0]  mem_rdata
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_RESP = 1'b1;

   logic                     state_ff, state_in;
   logic [CFG_W-1:0]         init_ff, init_in;
   logic [CFG_W-1:0]         blk_ff, blk_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         cap_ff, cap_in;
   status_type               pend_status_ff, pend_status_in;
   logic                     pend_use_ff, pend_use_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;

   logic                     accept;
   logic                     finish;
   status_type               op_status;
   logic                     op_use;
   logic [CNT_W-1:0]         op_count;
   logic [CNT_W-1:0]         op_cap;
   logic [CNT_W-1:0]         eff_init;
   logic [CNT_W:0]           grow_sum;
   logic [CNT_W:0]           shrink_floor;
   logic [CNT_W:0]           free_slots;
   logic [CNT_W-1:0]         count_dec;
   logic [CNT_W-1:0]         slot_dec;
   logic [CFG_W-1:0]         cfg_init;
   logic [CFG_W-1:0]         cfg_blk;

   assign req_if.ready = (state_ff == S_IDLE) && !clear_busy;
   assign accept       = req_if.valid && req_if.ready;
   assign finish       = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_if.ready);

   assign eff_init     = eff_initial(init_ff);
   assign grow_sum     = {1'b0, cap_ff} + {1'b0, blk_ff};
   assign count_dec    = count_ff - CNT_W'(1);
   assign slot_dec     = req_if.slot_index - CNT_W'(1);
   assign shrink_floor = {1'b0, eff_init} + {1'b0, blk_ff};
   assign free_slots   = {1'b0, cap_ff} - {1'b0, count_dec};

   // Decode of the accepted operation: new counters, status and memory access.
   always_comb begin
      op_status = ST_OK;
      op_use    = 1'b0;
      op_count  = count_ff;
      op_cap    = cap_ff;
      mem_req   = '0;
      if (init_ff == '0 && blk_ff == '0) begin
         op_status = ST_NOINIT;
      end else begin
         unique case (req_if.func)
            FN_PUSH: begin
               if (count_ff < cap_ff || (blk_ff != '0 && grow_sum <= (CNT_W+1)'(DEPTH))) begin
                  mem_req.we    = count_ff < CNT_W'(DEPTH);
                  mem_req.waddr = count_ff[ADDR_W-1:0];
                  mem_req.wdata = req_if.value_in;
                  op_count      = count_ff + CNT_W'(1);
                  if (count_ff >= cap_ff) begin
                     op_cap = grow_sum[CNT_W-1:0];
                  end
               end else if (blk_ff == '0) begin
                  op_status = ST_OVERFLOW;
               end else begin
                  op_status = ST_ALLOC;
               end
            end
            FN_POP: begin
               if (count_ff == '0) begin
                  op_status = ST_UNDERFLOW;
               end else begin
                  op_count      = count_dec;
                  op_use        = 1'b1;
                  mem_req.re    = 1'b1;
                  mem_req.raddr = count_dec[ADDR_W-1:0];
                  if ({1'b0, cap_ff} >= shrink_floor && free_slots >= {blk_ff, 1'b0}) begin
                     op_cap = cap_ff - blk_ff;
                  end
               end
            end
            FN_GET, FN_SET: begin
               if (req_if.slot_index == '0 || req_if.slot_index > cap_ff ||
                   req_if.slot_index > CNT_W'(DEPTH)) begin
                  op_status = ST_INDEX;
               end else if (req_if.func == FN_GET) begin
                  op_use        = 1'b1;
                  mem_req.re    = 1'b1;
                  mem_req.raddr = slot_dec[ADDR_W-1:0];
               end else begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = slot_dec[ADDR_W-1:0];
                  mem_req.wdata = req_if.value_in;
               end
            end
            default: begin
               op_status = ST_OK;
            end
         endcase
      end
      if (!accept) begin
         mem_req = '0;
      end
   end

   always_comb begin
      cfg_init = init_ff;
      cfg_blk  = blk_ff;
      unique case (csr_index)
         CSR_INIT_CAP:   cfg_init = csr_wdata;
         CSR_BLOCK_SIZE: cfg_blk  = csr_wdata;
         default:        cfg_init = init_ff;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      init_in        = init_ff;
      blk_in         = blk_ff;
      count_in       = count_ff;
      cap_in         = cap_ff;
      pend_status_in = pend_status_ff;
      pend_use_in    = pend_use_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_count_in   = rsp_count_ff;
      if (csr_we) begin
         init_in  = cfg_init;
         blk_in   = cfg_blk;
         count_in = '0;
         cap_in   = eff_initial(cfg_init);
      end else if (accept) begin
         count_in       = op_count;
         cap_in         = op_cap;
         pend_status_in = op_status;
         pend_use_in    = op_use;
         state_in       = S_RESP;
      end
      // The read data arrives in the cycle after the transaction and the RAM holds it.
      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pend_status_ff;
         rsp_value_in  = pend_use_ff ? $signed(mem_rdata) : '0;
         rsp_count_in  = count_ff;
         state_in      = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         init_ff      <= INIT_CAP_RESET;
         blk_ff       <= BLOCK_SIZE_RESET;
         count_ff     <= '0;
         cap_ff       <= eff_initial(INIT_CAP_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         blk_ff       <= blk_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_use_ff    <= pend_use_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.value_out  = rsp_value_ff;
   assign rsp_if.item_count = rsp_count_ff;

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_if.ready)
      else $error("request taken during the clearing pass");

   a_count_within_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_ff)
      else $error("item count exceeds the capacity");

   a_cap_within_depth: assert property (@(posedge clock) disable iff (reset)
      cap_ff <= CNT_W'(DEPTH))
      else $error("capacity exceeds the store depth");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.we && mem_req.re))
      else $error("one operation both reads and writes the store");

   a_accept_to_resp: assert property (@(posedge clock) disable iff (reset)
      accept && !csr_we |=> state_ff == S_RESP)
      else $error("accepted transaction did not enter the response state");

endmodule

`default_nettype wire

// File: design/block_grown_vector_stack_unit.sv
// Top level of the grown vector stack: store clearing sweep, item memory and controller.
// After a request is accepted, the controller enters its response state, then registers the
// response once any earlier one is taken; no new request is accepted until it is registered.
// A pending response may wait in the output register while the next request is accepted.
// Reset (synchronous, active high) restores the configuration, count and capacity at once,
// then writes zero to all 1024 store entries while req ready stays low.
`timescale 1ns / 1ps
`default_nettype none

module block_grown_vector_stack_unit import bgvs_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   bgvs_req_if.sink              req_if,
   bgvs_rsp_if.source            rsp_if,
   input  wire logic             csr_we,
   input  wire csr_index_type    csr_index,
   input  wire logic [CFG_W-1:0] csr_wdata
);

   logic              clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   mem_req_type       mem_req;
   logic [DATA_W-1:0] mem_rdata;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [DATA_W-1:0] ram_wdata;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // The sweep owns the write port until every entry holds zero.
   assign ram_we    = clr_busy_ff ? 1'b1 : mem_req.we;
   assign ram_waddr = clr_busy_ff ? clr_addr_ff : mem_req.waddr;
   assign ram_wdata = clr_busy_ff ? '0 : mem_req.wdata;

   bgvs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (mem_req.re),
      .raddr (mem_req.raddr),
      .rdata (mem_rdata)
   );

   bgvs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .clear_busy (clr_busy_ff),
      .req_if     (req_if),
      .rsp_if     (rsp_if),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mem_req    (mem_req),
      .mem_rdata  (mem_rdata)
   );

endmodule

`default_nettype wire
